// ----- rtl/q2e_pkg.sv -----
// Shared constants, widths and the CORDIC angle table for the quaternion to Euler block.
package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 7;
    localparam int ACC_FRAC         = 20;
    localparam int ARGW             = 34;
    localparam int XW               = 44;
    localparam int AW               = 32;
    localparam int PRE_SH           = 8;
    localparam int SQ_STEPS         = 31;
    localparam int SQ_QW            = 32;
    localparam int SQ_RW            = SQ_QW + 3;
    localparam int SQ_NW            = 2 * SQ_STEPS;

    localparam logic signed [AW-1:0] DEG180 = 32'sd188743680;

    function automatic logic signed [AW-1:0] atan_deg(input int i);
        case (i)
            0:  return 32'sd47185920;
            1:  return 32'sd27855475;
            2:  return 32'sd14718068;
            3:  return 32'sd7471121;
            4:  return 32'sd3750058;
            5:  return 32'sd1876857;
            6:  return 32'sd938658;
            7:  return 32'sd469357;
            8:  return 32'sd234682;
            9:  return 32'sd117342;
            10: return 32'sd58671;
            11: return 32'sd29335;
            12: return 32'sd14668;
            13: return 32'sd7334;
            14: return 32'sd3667;
            15: return 32'sd1833;
            16: return 32'sd917;
            17: return 32'sd458;
            18: return 32'sd229;
            19: return 32'sd115;
            20: return 32'sd57;
            21: return 32'sd29;
            22: return 32'sd14;
            23: return 32'sd7;
            default: return '0;
        endcase
    endfunction

endpackage

// ----- rtl/q2e_sqrt_cell.sv -----
// One digit step of the pipelined integer square root.
module q2e_sqrt_cell
    import q2e_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_ce,
    input  logic [SQ_RW-1:0]   i_rem,
    input  logic [SQ_QW-1:0]   i_root,
    input  logic [SQ_NW-1:0]   i_rad,
    output logic [SQ_RW-1:0]   o_rem,
    output logic [SQ_QW-1:0]   o_root,
    output logic [SQ_NW-1:0]   o_rad
);

    logic [SQ_RW-1:0] r_rem, n_rem;
    logic [SQ_QW-1:0] r_root, n_root;
    logic [SQ_NW-1:0] r_rad, n_rad;
    logic [SQ_RW-1:0] w_sh, w_trial;

    always_comb begin
        w_sh    = {i_rem[SQ_RW-3:0], i_rad[SQ_NW-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        n_rad   = {i_rad[SQ_NW-3:0], 2'b00};
        if (w_sh >= w_trial) begin
            n_rem  = w_sh - w_trial;
            n_root = {i_root[SQ_QW-2:0], 1'b1};
        end else begin
            n_rem  = w_sh;
            n_root = {i_root[SQ_QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

// ----- rtl/q2e_cordic_cell.sv -----
// One vectoring CORDIC rotation with a fixed shift.
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [AW-1:0] i_acc,
    input  logic                 i_zero,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [AW-1:0] o_acc,
    output logic                 o_zero
);

    localparam logic signed [AW-1:0] ANG = atan_deg(STEP);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y, w_dx, w_dy;
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_zero;

    always_comb begin
        w_dx = i_y >>> STEP;
        w_dy = i_x >>> STEP;
        if (!i_y[XW-1]) begin
            n_x   = i_x + w_dx;
            n_y   = i_y - w_dy;
            n_acc = i_acc + ANG;
        end else begin
            n_x   = i_x - w_dx;
            n_y   = i_y + w_dy;
            n_acc = i_acc - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= i_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_zero = r_zero;

endmodule

// ----- rtl/q2e_cordic.sv -----
// atan2 lane: quadrant fold, chain of CORDIC cells, rounding and saturation.
module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int STEPS     = CORDIC_STEPS_DEF,
    parameter int FRAC      = ANGLE_FRAC_DEF,
    parameter int LIMIT_DEG = 180
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ce,
    input  logic signed [ARGW-1:0] i_y,
    input  logic signed [ARGW-1:0] i_x,
    output logic signed [AW-1:0]   o_angle
);

    localparam int SH = ACC_FRAC - FRAC;
    localparam logic signed [AW-1:0] LIM  = AW'(LIMIT_DEG * (2 ** FRAC));
    localparam logic signed [AW-1:0] HALF = AW'(2 ** (SH - 1));

    logic signed [XW-1:0] w_x [0:STEPS];
    logic signed [XW-1:0] w_y [0:STEPS];
    logic signed [AW-1:0] w_acc [0:STEPS];
    logic                 w_zero [0:STEPS];

    logic signed [XW-1:0] r_x0, r_y0, n_x0, n_y0, w_xs, w_ys;
    logic signed [AW-1:0] r_acc0, n_acc0, r_ang, n_ang, w_sum, w_rnd;
    logic                 r_zero0, n_zero0;

    always_comb begin
        w_xs    = {{(XW-ARGW-PRE_SH){i_x[ARGW-1]}}, i_x, {PRE_SH{1'b0}}};
        w_ys    = {{(XW-ARGW-PRE_SH){i_y[ARGW-1]}}, i_y, {PRE_SH{1'b0}}};
        n_zero0 = (i_x == '0) && (i_y == '0);
        if (i_x[ARGW-1]) begin
            n_x0   = -w_xs;
            n_y0   = -w_ys;
            n_acc0 = i_y[ARGW-1] ? -DEG180 : DEG180;
        end else begin
            n_x0   = w_xs;
            n_y0   = w_ys;
            n_acc0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_acc0  <= n_acc0;
            r_zero0 <= n_zero0;
        end
    end

    assign w_x[0]    = r_x0;
    assign w_y[0]    = r_y0;
    assign w_acc[0]  = r_acc0;
    assign w_zero[0] = r_zero0;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        q2e_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_ce   (i_ce),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_acc  (w_acc[g]),
            .i_zero (w_zero[g]),
            .o_x    (w_x[g+1]),
            .o_y    (w_y[g+1]),
            .o_acc  (w_acc[g+1]),
            .o_zero (w_zero[g+1])
        );
    end

    always_comb begin
        w_sum = w_acc[STEPS] + HALF;
        w_rnd = w_sum >>> SH;
        if (w_zero[STEPS]) begin
            n_ang = '0;
        end else if (w_rnd > LIM) begin
            n_ang = LIM;
        end else if (w_rnd < -LIM) begin
            n_ang = -LIM;
        end else begin
            n_ang = w_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ang <= n_ang;
        end
    end

    assign o_angle = r_ang;

    // data registers are not reset, so the lane holds unknowns until flushed
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_ce) && !$isunknown(r_ang)) |-> (r_ang <= LIM))
        else $error("angle above limit");
    a_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_ce) && !$isunknown(r_ang)) |-> (r_ang >= -LIM))
        else $error("angle below limit");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ce && w_zero[STEPS]) |=> (r_ang == '0))
        else $error("zero vector gave nonzero angle");

endmodule

// ----- rtl/quaternion_to_euler_degrees_top.sv -----
// Quaternion to Euler angles in degrees: products, asin clamp, square root and three CORDIC lanes.
//
// Input word on s_axis tdata: quat_w, quat_x, quat_y, quat_z, each signed Q1.15.
// Output word on m_axis tdata: angle_x, angle_y, angle_z in degrees with
// ANGLE_FRAC_BITS fraction bits; tuser carries asin_clamped.
// One output word per input word, in order.
// Throughput: one word per cycle, no stall cycles of its own.
// Pipeline from accept to o_m_axis_tvalid: registers for the products, sums,
//   clamp, squaring and the 1 - a*a radicand, 31 square-root cells, one fold
//   stage, CORDIC_STEPS rotation cells and one rounding stage that is also
//   the output register.
// The whole pipeline advances together; when the output word is held by
// i_m_axis_tready low, every stage holds and o_s_axis_tready is low.
// Reset clears the valid line only; data registers are not reset.
module quaternion_to_euler_degrees_top
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // angle_x, angle_y, angle_z, zero pad
    output logic        o_m_axis_tuser    // asin_clamped
);

    localparam int LAT   = CORDIC_STEPS + 38;
    localparam int D_XZ  = 34;
    localparam int D_FLG = CORDIC_STEPS + 35;
    localparam int D_A   = 33;
    localparam logic signed [ARGW-1:0] UNIT = ARGW'(64'sd1073741824);

    logic w_ce;
    logic r_vld [0:LAT-1];

    logic signed [15:0] w_w, w_x, w_y, w_z;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_yz, r_xw, r_xy, r_zw, r_yw, r_xz;
    logic signed [ARGW-1:0] r_xa_y, r_xa_x, r_za_y, r_za_x, r_asin;
    logic signed [ARGW-1:0] n_xa_y, n_xa_x, n_za_y, n_za_x, n_asin;
    logic signed [31:0] r_a, n_a;
    logic               r_flag, n_flag;
    logic        [30:0] w_mag;
    logic        [61:0] r_aa;
    logic [SQ_NW-1:0]   r_n;

    logic signed [ARGW-1:0] r_dxy [0:D_XZ-1];
    logic signed [ARGW-1:0] r_dxx [0:D_XZ-1];
    logic signed [ARGW-1:0] r_dzy [0:D_XZ-1];
    logic signed [ARGW-1:0] r_dzx [0:D_XZ-1];
    logic signed [31:0]     r_da  [0:D_A-1];
    logic                   r_dfl [0:D_FLG-1];

    logic [SQ_RW-1:0] w_rem  [0:SQ_STEPS];
    logic [SQ_QW-1:0] w_root [0:SQ_STEPS];
    logic [SQ_NW-1:0] w_rad  [0:SQ_STEPS];

    logic signed [ARGW-1:0] w_cos;
    logic signed [AW-1:0]   w_ang_x, w_ang_y, w_ang_z;

    assign w_ce            = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    assign w_w = i_s_axis_tdata[15:0];
    assign w_x = i_s_axis_tdata[31:16];
    assign w_y = i_s_axis_tdata[47:32];
    assign w_z = i_s_axis_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_ce) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_comb begin
        n_xa_y = (ARGW'(r_yz) + ARGW'(r_xw)) <<< 1;
        n_xa_x = ARGW'(r_ww) - ARGW'(r_xx) - ARGW'(r_yy) + ARGW'(r_zz);
        n_za_y = (ARGW'(r_xy) + ARGW'(r_zw)) <<< 1;
        n_za_x = ARGW'(r_ww) + ARGW'(r_xx) - ARGW'(r_yy) - ARGW'(r_zz);
        n_asin = (ARGW'(r_yw) - ARGW'(r_xz)) <<< 1;
    end

    always_comb begin
        if (r_asin > UNIT) begin
            n_a    = 32'sd1073741824;
            n_flag = 1'b1;
        end else if (r_asin < -UNIT) begin
            n_a    = -32'sd1073741824;
            n_flag = 1'b1;
        end else begin
            n_a    = 32'(r_asin);
            n_flag = 1'b0;
        end
    end

    assign w_mag = r_a[31] ? 31'(-r_a) : r_a[30:0];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ww   <= w_w * w_w;
            r_xx   <= w_x * w_x;
            r_yy   <= w_y * w_y;
            r_zz   <= w_z * w_z;
            r_yz   <= w_y * w_z;
            r_xw   <= w_x * w_w;
            r_xy   <= w_x * w_y;
            r_zw   <= w_z * w_w;
            r_yw   <= w_y * w_w;
            r_xz   <= w_x * w_z;
            r_xa_y <= n_xa_y;
            r_xa_x <= n_xa_x;
            r_za_y <= n_za_y;
            r_za_x <= n_za_x;
            r_asin <= n_asin;
            r_a    <= n_a;
            r_flag <= n_flag;
            r_aa   <= w_mag * w_mag;
            r_n    <= (SQ_NW'(1) << 60) - r_aa;
            r_dxy[0] <= r_xa_y;
            r_dxx[0] <= r_xa_x;
            r_dzy[0] <= r_za_y;
            r_dzx[0] <= r_za_x;
            for (int i = 1; i < D_XZ; i++) begin
                r_dxy[i] <= r_dxy[i-1];
                r_dxx[i] <= r_dxx[i-1];
                r_dzy[i] <= r_dzy[i-1];
                r_dzx[i] <= r_dzx[i-1];
            end
            r_da[0]  <= r_a;
            r_dfl[0] <= r_flag;
            for (int i = 1; i < D_A; i++) begin
                r_da[i] <= r_da[i-1];
            end
            for (int i = 1; i < D_FLG; i++) begin
                r_dfl[i] <= r_dfl[i-1];
            end
        end
    end

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = r_n;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        q2e_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .i_rad  (w_rad[g]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1]),
            .o_rad  (w_rad[g+1])
        );
    end

    assign w_cos = ARGW'(w_root[SQ_STEPS]);

    q2e_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .LIMIT_DEG(180)) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_y     (r_dxy[D_XZ-1]),
        .i_x     (r_dxx[D_XZ-1]),
        .o_angle (w_ang_x)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .LIMIT_DEG(90)) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_y     (ARGW'(r_da[D_A-1])),
        .i_x     (w_cos),
        .o_angle (w_ang_y)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS), .FRAC(ANGLE_FRAC_BITS), .LIMIT_DEG(180)) u_lane_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_y     (r_dzy[D_XZ-1]),
        .i_x     (r_dzx[D_XZ-1]),
        .o_angle (w_ang_z)
    );

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = {1'b0, w_ang_z[15:0], w_ang_y[14:0], w_ang_x[15:0]};
    assign o_m_axis_tuser  = r_dfl[D_FLG-1];

    a_clamp_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |-> (r_a == 32'sd1073741824 || r_a == -32'sd1073741824))
        else $error("clamp flag without unit argument");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_dfl[D_FLG-1]))
        else $error("flag changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

endmodule
